// ----- design/sdspi_pkg.sv -----
// package: types, phase codes and constants for the sd spi host controller
package sdspi_pkg;

    localparam int BLOCK_BYTES = 512;

    localparam logic [1:0] FUNC_INIT  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;
    localparam logic [1:0] FUNC_XCHG  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FAIL    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    localparam logic [2:0] CFG_IDLE_RETRY   = 3'd0;
    localparam logic [2:0] CFG_OPCOND_RETRY = 3'd1;
    localparam logic [2:0] CFG_READY_WAIT   = 3'd2;
    localparam logic [2:0] CFG_RESP_POLL    = 3'd3;
    localparam logic [2:0] CFG_WAKE_COUNT   = 3'd4;

    localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
    localparam logic [5:0] CMD_SEND_OP   = 6'd1;
    localparam logic [5:0] CMD_IF_COND   = 6'd8;
    localparam logic [5:0] CMD_BLOCKLEN  = 6'd16;
    localparam logic [5:0] CMD_READ_BLK  = 6'd17;
    localparam logic [5:0] CMD_WRITE_BLK = 6'd24;
    localparam logic [5:0] CMD_APP_OP    = 6'd41;
    localparam logic [5:0] CMD_APP       = 6'd55;
    localparam logic [5:0] CMD_GET_OCR   = 6'd58;

    localparam logic [7:0] BYTE_IDLE  = 8'hFF;
    localparam logic [7:0] TOKEN_DATA = 8'hFE;
    localparam logic [7:0] CRC_CMD0   = 8'h95;
    localparam logic [7:0] CRC_CMD8   = 8'h87;
    localparam logic [7:0] CHECK_AA   = 8'hAA;
    localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
    localparam logic [31:0] ARG_HCS     = 32'h4000_0000;

    typedef enum logic [5:0] {
        P_IDLE, P_WAKE, P_GO_IDLE, P_IF_COND, P_IF_TAIL, P_APP_PROBE, P_OP_PROBE,
        P_APP_LOOP, P_OP_LOOP, P_OCR, P_OCR_TAIL, P_BLOCKLEN,
        P_RD_CMD, P_RD_TOKEN, P_RD_DATA, P_RD_CRC,
        P_WR_CMD, P_WR_TOKEN, P_WR_DATA, P_WR_CRC, P_WR_BUSY, P_WR_TAIL
    } t_phase;

    typedef struct packed {
        logic [15:0] idle_retry_limit;
        logic [15:0] opcond_retry_limit;
        logic [15:0] ready_wait_limit;
        logic [7:0]  response_poll_limit;
        logic [7:0]  wake_byte_count;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] retry_count;
        logic [9:0]  byte_count;
        logic [2:0]  type_bits;
        logic [31:0] command_argument;
        logic [5:0]  command_index;
        logic [7:0]  last_response;
    } t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] block_addr;
        logic [7:0]  card_byte;
        logic [7:0]  write_byte;
    } t_item;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       card_select;
        logic       slow_clock;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       need_write_byte;
        logic       done_res;
        logic [1:0] status;
        logic [2:0] card_type;
    } t_result;

endpackage

// ----- design/sdspi_step.sv -----
// next-state and result logic for one byte exchange step
module sdspi_step
    import sdspi_pkg::*;
(
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    input  t_item   i_item,
    output t_state  o_state,
    output t_result o_result
);

    t_state  s;
    t_result r;
    logic [7:0] c;
    logic [31:0] addr;
    logic [9:0] k;
    logic [9:0] p;
    logic [7:0] lim;
    logic [7:0] wake;
    logic resp;
    logic [7:0] rv;
    logic is_cmd;
    logic is_try;

    function automatic logic [7:0] f_cmd_byte(input logic [9:0] kk, input t_phase ph,
                                              input logic [5:0] idx,
                                              input logic [31:0] a);
        logic [7:0] b;
        b = BYTE_IDLE;
        unique case (kk)
            10'd1: b = {2'b01, idx};
            10'd2: b = a[31:24];
            10'd3: b = a[23:16];
            10'd4: b = a[15:8];
            10'd5: b = a[7:0];
            10'd6: begin
                if (ph == P_RD_CMD || ph == P_WR_CMD) b = BYTE_IDLE;
                else if (idx == CMD_GO_IDLE) b = CRC_CMD0;
                else if (idx == CMD_IF_COND) b = CRC_CMD8;
                else b = BYTE_IDLE;
            end
            default: b = BYTE_IDLE;
        endcase
        return b;
    endfunction

    always_comb begin
        s = i_state;
        r = '0;
        c = i_item.card_byte;
        k = i_state.byte_count;
        p = k - 10'd7;
        lim = (i_cfg.response_poll_limit == 8'd0) ? 8'd1 : i_cfg.response_poll_limit;
        wake = (i_cfg.wake_byte_count == 8'd0) ? 8'd1 : i_cfg.wake_byte_count;
        addr = i_state.type_bits[2] ? i_item.block_addr : {i_item.block_addr[22:0], 9'd0};
        resp = 1'b0;
        rv = c;
        is_try = (i_state.phase == P_RD_CMD || i_state.phase == P_WR_CMD);
        is_cmd = is_try || i_state.phase == P_GO_IDLE || i_state.phase == P_IF_COND ||
                 i_state.phase == P_APP_PROBE || i_state.phase == P_OP_PROBE ||
                 i_state.phase == P_APP_LOOP || i_state.phase == P_OP_LOOP ||
                 i_state.phase == P_OCR || i_state.phase == P_BLOCKLEN;

        unique case (i_item.func)
            FUNC_INIT: begin
                s.type_bits = '0;
                s.phase = P_WAKE;
                s.byte_count = '0;
                s.retry_count = '0;
                r.send_valid = 1'b1;
                r.send_byte = BYTE_IDLE;
            end
            FUNC_READ, FUNC_WRITE: begin
                s.phase = (i_item.func == FUNC_READ) ? P_RD_CMD : P_WR_CMD;
                s.command_index = (i_item.func == FUNC_READ) ? CMD_READ_BLK : CMD_WRITE_BLK;
                s.command_argument = addr;
                s.byte_count = '0;
                r.send_valid = 1'b1;
                r.send_byte = BYTE_IDLE;
            end
            default: begin
                if (i_state.phase == P_IDLE) begin
                end else if (is_cmd) begin
                    if (k < 10'd7) begin
                        s.byte_count = k + 10'd1;
                        r.send_valid = 1'b1;
                        r.send_byte = f_cmd_byte(k + 10'd1, i_state.phase,
                                                 i_state.command_index,
                                                 i_state.command_argument);
                    end else if (c == BYTE_IDLE) begin
                        if (is_try && p >= {2'b00, lim}) begin
                            s.phase = P_IDLE;
                            r.done_res = 1'b1;
                            r.status = ST_TIMEOUT;
                        end else if (!is_try && (p + 10'd1) >= {2'b00, lim}) begin
                            resp = 1'b1;
                        end else begin
                            s.byte_count = k + 10'd1;
                            r.send_valid = 1'b1;
                            r.send_byte = BYTE_IDLE;
                        end
                    end else begin
                        resp = 1'b1;
                    end
                end else begin
                    unique case (i_state.phase)
                        P_WAKE: begin
                            if ((k + 10'd1) < {2'b00, wake}) begin
                                s.byte_count = k + 10'd1;
                            end else begin
                                s.retry_count = '0;
                                s.phase = P_GO_IDLE;
                                s.command_index = CMD_GO_IDLE;
                                s.command_argument = '0;
                                s.byte_count = '0;
                            end
                            r.send_valid = 1'b1;
                            r.send_byte = BYTE_IDLE;
                        end
                        P_IF_TAIL: begin
                            if (k == 10'd2 && !c[0]) begin
                                s.phase = P_IDLE;
                                r.done_res = 1'b1;
                                r.status = ST_FAIL;
                            end else if (k < 10'd3) begin
                                s.byte_count = k + 10'd1;
                                r.send_valid = 1'b1;
                                r.send_byte = BYTE_IDLE;
                            end else if (c != CHECK_AA) begin
                                s.phase = P_IDLE;
                                r.done_res = 1'b1;
                                r.status = ST_FAIL;
                            end else begin
                                s.type_bits = i_state.type_bits | 3'b010;
                                s.retry_count = '0;
                                s.phase = P_APP_LOOP;
                                s.command_index = CMD_APP;
                                s.command_argument = '0;
                                s.byte_count = '0;
                                r.send_valid = 1'b1;
                                r.send_byte = BYTE_IDLE;
                            end
                        end
                        P_OCR_TAIL: begin
                            if (k == 10'd0 && c[6]) s.type_bits = i_state.type_bits | 3'b100;
                            if (k < 10'd3) begin
                                s.byte_count = k + 10'd1;
                            end else begin
                                s.phase = P_BLOCKLEN;
                                s.command_index = CMD_BLOCKLEN;
                                s.command_argument = 32'(BLOCK_BYTES);
                                s.byte_count = '0;
                            end
                            r.send_valid = 1'b1;
                            r.send_byte = BYTE_IDLE;
                        end
                        P_RD_TOKEN, P_WR_BUSY: begin
                            if (c == ((i_state.phase == P_RD_TOKEN) ? TOKEN_DATA : BYTE_IDLE))
                            begin
                                s.phase = (i_state.phase == P_RD_TOKEN) ? P_RD_DATA : P_WR_TAIL;
                                s.byte_count = '0;
                                r.send_valid = 1'b1;
                                r.send_byte = BYTE_IDLE;
                            end else if (i_state.retry_count == i_cfg.ready_wait_limit) begin
                                s.phase = P_IDLE;
                                r.done_res = 1'b1;
                                r.status = ST_TIMEOUT;
                            end else begin
                                s.retry_count = i_state.retry_count + 16'd1;
                                r.send_valid = 1'b1;
                                r.send_byte = BYTE_IDLE;
                            end
                        end
                        P_RD_DATA: begin
                            r.read_valid = 1'b1;
                            r.read_byte = c;
                            if ({1'b0, k} + 11'd1 < 11'(BLOCK_BYTES)) begin
                                s.byte_count = k + 10'd1;
                            end else begin
                                s.phase = P_RD_CRC;
                                s.byte_count = '0;
                            end
                            r.send_valid = 1'b1;
                            r.send_byte = BYTE_IDLE;
                        end
                        P_RD_CRC: begin
                            if (k < 10'd2) begin
                                s.byte_count = k + 10'd1;
                                r.send_valid = 1'b1;
                                r.send_byte = BYTE_IDLE;
                            end else begin
                                s.phase = P_IDLE;
                                r.done_res = 1'b1;
                                r.status = ST_OK;
                            end
                        end
                        P_WR_TOKEN: begin
                            s.phase = P_WR_DATA;
                            s.byte_count = '0;
                            r.send_valid = 1'b1;
                            r.send_byte = i_item.write_byte;
                            r.need_write_byte = 1'b1;
                        end
                        P_WR_DATA: begin
                            r.send_valid = 1'b1;
                            // the compare against block size 512 is done at 11 bits, one wider than the 10-bit count
                            if ({1'b0, k} + 11'd1 < 11'(BLOCK_BYTES)) begin
                                s.byte_count = k + 10'd1;
                                r.send_byte = i_item.write_byte;
                                r.need_write_byte = ({1'b0, k} + 11'd2) < 11'(BLOCK_BYTES);
                            end else begin
                                s.phase = P_WR_CRC;
                                s.byte_count = '0;
                                r.send_byte = BYTE_IDLE;
                            end
                        end
                        P_WR_CRC: begin
                            if (k == 10'd0) begin
                                s.byte_count = k + 10'd1;
                            end else begin
                                s.phase = P_WR_BUSY;
                                s.retry_count = '0;
                            end
                            r.send_valid = 1'b1;
                            r.send_byte = BYTE_IDLE;
                        end
                        P_WR_TAIL: begin
                            s.phase = P_IDLE;
                            r.done_res = 1'b1;
                            r.status = ST_OK;
                        end
                        default: begin
                        end
                    endcase
                end

                // command response handling
                if (resp) begin
                    s.last_response = rv;
                    r.send_valid = 1'b1;
                    r.send_byte = BYTE_IDLE;
                    s.byte_count = '0;
                    unique case (i_state.phase)
                        P_GO_IDLE: begin
                            if (rv == 8'd1) begin
                                s.phase = P_IF_COND;
                                s.command_index = CMD_IF_COND;
                                s.command_argument = ARG_IF_COND;
                            end else if (i_state.retry_count == i_cfg.idle_retry_limit) begin
                                s.phase = P_IDLE;
                                r = '0;
                                r.done_res = 1'b1;
                                r.status = ST_TIMEOUT;
                            end else begin
                                s.retry_count = i_state.retry_count + 16'd1;
                                s.command_index = CMD_GO_IDLE;
                                s.command_argument = '0;
                            end
                        end
                        P_IF_COND: begin
                            if (!rv[2]) begin
                                s.phase = P_IF_TAIL;
                            end else begin
                                s.phase = P_APP_PROBE;
                                s.command_index = CMD_APP;
                                s.command_argument = '0;
                            end
                        end
                        P_APP_PROBE: begin
                            s.phase = P_OP_PROBE;
                            s.command_index = CMD_APP_OP;
                            s.command_argument = '0;
                        end
                        P_OP_PROBE: begin
                            s.type_bits = i_state.type_bits | {2'b00, ~rv[2]};
                            s.retry_count = '0;
                            s.command_argument = '0;
                            if ((i_state.type_bits[1:0] != 2'b00) || !rv[2]) begin
                                s.phase = P_APP_LOOP;
                                s.command_index = CMD_APP;
                            end else begin
                                s.phase = P_OP_LOOP;
                                s.command_index = CMD_SEND_OP;
                            end
                        end
                        P_APP_LOOP: begin
                            s.phase = P_OP_LOOP;
                            s.command_index = CMD_APP_OP;
                            s.command_argument = i_state.type_bits[1] ? ARG_HCS : '0;
                        end
                        P_OP_LOOP: begin
                            if (!rv[0]) begin
                                if (i_state.type_bits[1]) begin
                                    s.phase = P_OCR;
                                    s.command_index = CMD_GET_OCR;
                                    s.command_argument = '0;
                                end else begin
                                    s.phase = P_BLOCKLEN;
                                    s.command_index = CMD_BLOCKLEN;
                                    s.command_argument = 32'(BLOCK_BYTES);
                                end
                            end else if (i_state.retry_count == i_cfg.opcond_retry_limit) begin
                                s.phase = P_IDLE;
                                r = '0;
                                r.done_res = 1'b1;
                                r.status = ST_TIMEOUT;
                            end else begin
                                s.retry_count = i_state.retry_count + 16'd1;
                                s.command_argument = '0;
                                if (i_state.type_bits[1:0] != 2'b00) begin
                                    s.phase = P_APP_LOOP;
                                    s.command_index = CMD_APP;
                                end else begin
                                    s.phase = P_OP_LOOP;
                                    s.command_index = CMD_SEND_OP;
                                end
                            end
                        end
                        P_OCR: begin
                            if (rv != 8'd0) begin
                                s.phase = P_IDLE;
                                r = '0;
                                r.done_res = 1'b1;
                                r.status = ST_FAIL;
                            end else begin
                                s.phase = P_OCR_TAIL;
                            end
                        end
                        P_BLOCKLEN: begin
                            s.phase = P_IDLE;
                            r = '0;
                            r.done_res = 1'b1;
                            r.status = (rv != 8'd0) ? ST_FAIL : ST_OK;
                        end
                        P_RD_CMD: begin
                            if (rv != 8'd0) begin
                                s.phase = P_IDLE;
                                r = '0;
                                r.done_res = 1'b1;
                                r.status = ST_FAIL;
                            end else begin
                                s.phase = P_RD_TOKEN;
                                s.retry_count = '0;
                                s.byte_count = i_state.byte_count;
                            end
                        end
                        default: begin
                            if (rv != 8'd0) begin
                                s.phase = P_IDLE;
                                r = '0;
                                r.done_res = 1'b1;
                                r.status = ST_FAIL;
                            end else begin
                                s.phase = P_WR_TOKEN;
                                s.byte_count = i_state.byte_count;
                                r.send_byte = TOKEN_DATA;
                                r.need_write_byte = 1'b1;
                            end
                        end
                    endcase
                end
            end
        endcase

        r.card_select = (s.phase != P_IDLE) && (s.phase != P_WAKE);
        r.slow_clock = (s.phase >= P_WAKE) && (s.phase <= P_BLOCKLEN);
        r.card_type = s.type_bits;
        o_state = s;
        o_result = r;
    end

endmodule

// ----- design/sd_spi_host_controller_top.sv -----
// top level: stream ports, config registers, state and result registers
// the result of each accepted word is computed combinationally and held in the result register
// one word per cycle while m_axis_tready is high; the step logic sits between the state and result registers
// the output register is refilled in the same cycle it is taken, so tready holds high while m_axis_tready is high
// reset (i_rst_n low, synchronous) clears state, output valid and config to defaults
module sd_spi_host_controller_top
    import sdspi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[1:0], block_addr[33:2], card_byte[41:34], write_byte[49:42], zero pad
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // send_valid[0], send_byte[8:1], card_select[9], slow_clock[10], read_valid[11],
    // read_byte[19:12], need_write_byte[20], done_res[21], status[23:22],
    // card_type[26:24], zero pad
    output logic [31:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_valid;
    t_item   item;
    logic    take;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign take = s_axis_tvalid && s_axis_tready;
    assign item = '{func: s_axis_tdata[1:0], block_addr: s_axis_tdata[33:2],
                    card_byte: s_axis_tdata[41:34], write_byte: s_axis_tdata[49:42]};

    sdspi_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{idle_retry_limit: 16'd511, opcond_retry_limit: 16'd32767,
                       ready_wait_limit: 16'd65535, response_poll_limit: 8'd10,
                       wake_byte_count: 8'd10};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IDLE_RETRY:   r_cfg.idle_retry_limit <= i_cfg_data;
                CFG_OPCOND_RETRY: r_cfg.opcond_retry_limit <= i_cfg_data;
                CFG_READY_WAIT:   r_cfg.ready_wait_limit <= i_cfg_data;
                CFG_RESP_POLL:    r_cfg.response_poll_limit <= i_cfg_data[7:0];
                CFG_WAKE_COUNT:   r_cfg.wake_byte_count <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: P_IDLE, retry_count: '0, byte_count: '0, type_bits: '0,
                         command_argument: '0, command_index: '0, last_response: 8'hFF};
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_state <= n_state;
                r_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) r_result <= n_result;
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata = {5'd0, r_result.card_type, r_result.status, r_result.done_res,
                           r_result.need_write_byte, r_result.read_byte, r_result.read_valid,
                           r_result.slow_clock, r_result.card_select, r_result.send_byte,
                           r_result.send_valid};

`ifndef ASSERT_OFF
    a_card_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[26:24] == r_state.type_bits)
        else $error("card type differs from state");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[21]) |-> (r_state.phase == P_IDLE && !m_axis_tdata[0]))
        else $error("done while busy or sending");
    a_cs_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == P_IDLE) |-> !(m_axis_tvalid && m_axis_tdata[9]))
        else $error("select held while idle");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(r_state))
        else $error("state moved during stall");
`endif

endmodule
